@@ rtl/lcdq_pkg.sv @@
// shared types and constants for the text display command queue
package lcdq_pkg;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_ROW  = 2'd2;

	// special character codes
	localparam logic [7:0] NEWLINE_CODE   = 8'h0A;
	localparam logic [7:0] BACKSPACE_CODE = 8'h08;

	// display instructions
	localparam logic [7:0] ADDR_CMD_BASE = 8'h80;
	localparam logic [7:0] ADDR_MASK     = 8'h7F;
	localparam logic [7:0] CLEAR_CMD     = 8'h01;

	// register select values
	localparam logic SEL_INSTR = 1'b0;
	localparam logic SEL_DATA  = 1'b1;

	// cursor geometry: 4 rows of 16 cells
	localparam logic [6:0] CELL_COUNT      = 7'd64;
	localparam logic [6:0] ROW_CELLS       = 7'd16;
	localparam logic [6:0] CURSOR_ROW_MASK = 7'h70;

	// most commands one write request can queue
	localparam int MAX_PUSH = 3;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       bus_valid;
		logic       bus_reg_select;
		logic [7:0] bus_byte;
	} rsp_item_t;

	typedef struct packed {
		logic       sel;
		logic [7:0] cmd_byte;
	} cmd_t;

	typedef struct packed {
		logic [1:0]            count;
		cmd_t [MAX_PUSH-1:0]   ent;
	} push_t;

	typedef struct packed {
		logic [1:0] status;
		logic       bus_hit;
	} step_info_t;

	// display address of the first cell of each row
	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] base;
		unique case (row)
			2'd0: base = 8'h00;
			2'd1: base = 8'h10;
			2'd2: base = 8'h08;
			2'd3: base = 8'h18;
			default: base = 8'h00;
		endcase
		return base;
	endfunction

endpackage

@@ rtl/lcdq_ctrl.sv @@
// cursor, row flag and ring pointer logic for one accepted request per cycle
module lcdq_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  lcdq_pkg::req_item_t req,
	output logic                wr_load,
	output lcdq_pkg::push_t     push,
	output logic [AW-1:0]       wr_base,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	output lcdq_pkg::step_info_t info
);
	import lcdq_pkg::*;

	logic [6:0]    cursor_q;
	logic          pend_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;

	logic [6:0]    cursor_d;
	logic          pend_d;
	logic [AW-1:0] head_d;
	logic [AW-1:0] tail_d;
	logic          nonempty;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign nonempty = (head_q != tail_q);
	assign wr_base  = ring_next(head_q);
	assign rd_addr  = ring_next(tail_q);
	assign wr_load  = accept && (req.req_type == REQ_WRITE);
	assign rd_en    = accept && (req.req_type == REQ_TICK) && nonempty;

	always_comb begin
		logic          ok;
		logic [6:0]    cur;
		logic          pend;
		logic [AW-1:0] h;
		logic [1:0]    k;
		ok   = 1'b1;
		cur  = cursor_q;
		pend = pend_q;
		h    = head_q;
		k    = 2'd0;
		push = '0;
		info = '0;
		tail_d = tail_q;
		if (req.req_type == REQ_TICK) begin
			if (nonempty) begin
				tail_d = ring_next(tail_q);
				info.bus_hit = 1'b1;
			end
		end else begin
			// pending row address goes out first
			if (pend) begin
				if (ring_next(h) == tail_q) begin
					ok = 1'b0;
				end else begin
					push.ent[k] = '{sel: SEL_INSTR,
						cmd_byte: ADDR_CMD_BASE | (row_base(cur[5:4]) & ADDR_MASK)};
					k = k + 2'd1;
					h = ring_next(h);
					pend = 1'b0;
				end
			end
			// past the last cell: clear and home
			if (ok && cur == CELL_COUNT) begin
				if (ring_next(h) == tail_q) begin
					ok = 1'b0;
				end else begin
					push.ent[k] = '{sel: SEL_INSTR, cmd_byte: CLEAR_CMD};
					k = k + 2'd1;
					h = ring_next(h);
					cur = '0;
				end
			end
			if (ok) begin
				case (req.char_code)
					NEWLINE_CODE: begin
						cur = (cur & CURSOR_ROW_MASK) + ROW_CELLS;
					end
					BACKSPACE_CODE: begin
						if (cur != '0) begin
							cur = cur - 7'd1;
						end
					end
					default: begin
						if (ring_next(h) == tail_q) begin
							ok = 1'b0;
						end else begin
							push.ent[k] = '{sel: SEL_DATA, cmd_byte: req.char_code};
							k = k + 2'd1;
							h = ring_next(h);
							cur = cur + 7'd1;
						end
					end
				endcase
			end
			if (!ok) begin
				info.status = STATUS_FULL;
			end else if (cur[3:0] == 4'd0) begin
				pend = 1'b1;
				info.status = STATUS_ROW;
			end
		end
		push.count = k;
		cursor_d   = cur;
		pend_d     = pend;
		head_d     = h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			pend_q   <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
		end else if (accept) begin
			cursor_q <= cursor_d;
			pend_q   <= pend_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
		end
	end

endmodule

@@ rtl/lcdq_store.sv @@
// command ring memory with a small write buffer and read forwarding
module lcdq_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  lcdq_pkg::push_t push,
	input  logic [AW-1:0]   wr_base,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output logic            busy,
	output lcdq_pkg::cmd_t  rd_cmd
);
	import lcdq_pkg::*;

	cmd_t mem [DEPTH];

	logic [1:0]          cnt_q;
	cmd_t [MAX_PUSH-1:0] ent_q;
	logic [AW-1:0]       waddr_q;
	logic                wr_en;

	cmd_t rd_mem_s1;
	logic fwd_s1;
	cmd_t fwd_cmd_s1;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_en = (cnt_q != 2'd0);
	// a new load is only safe once at most the entry being written remains
	assign busy  = (cnt_q > 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= push.count;
		end else if (wr_en) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q   <= push.ent;
			waddr_q <= wr_base;
		end else if (wr_en) begin
			ent_q   <= {cmd_t'('0), ent_q[MAX_PUSH-1:1]};
			waddr_q <= ring_next(waddr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr_q] <= ent_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_mem_s1  <= mem[rd_addr];
			fwd_s1     <= wr_en && (waddr_q == rd_addr);
			fwd_cmd_s1 <= ent_q[0];
		end
	end

	assign rd_cmd = fwd_s1 ? fwd_cmd_s1 : rd_mem_s1;

endmodule

@@ rtl/lcd_text_cursor_command_queue_unit.sv @@
// top level of the text display cursor and command queue
//
// req channel: one transaction per request, req_type selects a character
//   write (cursor update, commands queued) or a tick (one command drained)
// rsp channel: exactly one transaction per request, in request order,
//   carrying status and the drained bus command (zeros when none)
// path: a result is registered in stage 1 and then in the response register
// throughput: one request per cycle while rsp_ready keeps up; a write that queues
//   more than one command holds req_ready low until at most one is left in the
//   write buffer, which the single memory write port drains one command per cycle
// queue: QUEUE_DEPTH entries in a one-port-write, one-port-read memory with
//   registered read data; usable capacity is QUEUE_DEPTH-1 commands
// reset: cursor, row flag, pointers and all valid flags clear; memory contents
//   are not cleared, entries are only read after being written
// stall: the response register parts the two sides, so one more request
//   is taken while a finished result waits on rsp_ready
module lcd_text_cursor_command_queue_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  lcdq_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output lcdq_pkg::rsp_item_t rsp
);
	import lcdq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic          accept;
	logic          wr_load;
	push_t         push;
	logic [AW-1:0] wr_base;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	step_info_t    info;
	logic          busy;
	cmd_t          rd_cmd;

	// stage 1: request decided, memory read in flight
	logic       valid_s1;
	step_info_t info_s1;
	logic       s1_move;

	// response register
	logic      rsp_valid_q;
	rsp_item_t rsp_q;
	rsp_item_t rsp_next;

	assign s1_move   = !rsp_valid_q || rsp_ready;
	assign req_ready = !busy && (!valid_s1 || s1_move);
	assign accept    = req_valid && req_ready;

	lcdq_ctrl #(
		.DEPTH(QUEUE_DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.wr_load(wr_load),
		.push   (push),
		.wr_base(wr_base),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.info   (info)
	);

	lcdq_store #(
		.DEPTH(QUEUE_DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (wr_load),
		.push   (push),
		.wr_base(wr_base),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.busy   (busy),
		.rd_cmd (rd_cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	// read data is held until stage 1 moves on, since the next read needs accept
	always_comb begin
		rsp_next.status         = info_s1.status;
		rsp_next.bus_valid      = info_s1.bus_hit;
		rsp_next.bus_reg_select = info_s1.bus_hit ? rd_cmd.sel : 1'b0;
		rsp_next.bus_byte       = info_s1.bus_hit ? rd_cmd.cmd_byte : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_move) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the text display cursor and command queue
`timescale 1ns / 100ps

module testbench;
	import lcdq_pkg::*;

	localparam int CMD_SLOTS     = 16;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_WAIT      = 17;
	localparam int REPORT_LIMIT  = 10;
	localparam int DRAIN_CYCLES  = 10;

	// one pending request, optionally held back until every result is back
	typedef struct packed {
		logic      hold_for_drain;
		req_item_t item;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	lcd_text_cursor_command_queue_unit #(
		.QUEUE_DEPTH(CMD_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor state: cursor, row flag and the command ring
	// ------------------------------------------------------------------
	logic [6:0] exp_cursor;
	logic       row_addr_due;
	int         ring_head;
	int         ring_tail;
	cmd_t       ring_cmds [CMD_SLOTS];

	// display address of the first cell of each row
	const logic [7:0] row_addr_table [4] = '{8'h00, 8'h10, 8'h08, 8'h18};

	stim_t     char_requests [$];
	rsp_item_t pending_results [$];

	int total_items;
	int accepted_count;
	int mismatch_count;
	int cycle_count;
	int req_gap_left;
	int rsp_stall_left;
	bit req_burst;
	bit rsp_burst;

	stim_t     next_stim;
	rsp_item_t predicted;

	// ring push, refused when the slot after the head is the tail
	function automatic bit queue_cmd(input logic sel, input logic [7:0] cmd_byte);
		int nh;
		nh = (ring_head + 1) % CMD_SLOTS;
		if (nh == ring_tail)
			return 1'b0;
		ring_head = nh;
		ring_cmds[nh].sel = sel;
		ring_cmds[nh].cmd_byte = cmd_byte;
		return 1'b1;
	endfunction

	// expected result of one request, advancing the predictor state
	function automatic rsp_item_t display_step(input req_item_t r);
		rsp_item_t  o;
		bit         ok;
		logic [7:0] addr;
		o = '0;
		o.status = STATUS_OK;
		if (r.req_type == REQ_TICK) begin
			if (ring_head != ring_tail) begin
				ring_tail = (ring_tail + 1) % CMD_SLOTS;
				o.bus_valid = 1'b1;
				o.bus_reg_select = ring_cmds[ring_tail].sel;
				o.bus_byte = ring_cmds[ring_tail].cmd_byte;
			end
		end else begin
			ok = 1'b1;
			// row address owed from an earlier row start, row index wraps mod 4
			if (row_addr_due) begin
				addr = row_addr_table[exp_cursor[5:4]];
				if (!queue_cmd(SEL_INSTR, ADDR_CMD_BASE | (addr & ADDR_MASK)))
					ok = 1'b0;
				else
					row_addr_due = 1'b0;
			end
			// past the last cell: clear the screen and home
			if (ok && exp_cursor == CELL_COUNT) begin
				if (!queue_cmd(SEL_INSTR, CLEAR_CMD))
					ok = 1'b0;
				else
					exp_cursor = '0;
			end
			if (ok) begin
				if (r.char_code == NEWLINE_CODE) begin
					exp_cursor = (exp_cursor & CURSOR_ROW_MASK) + ROW_CELLS;
				end else if (r.char_code == BACKSPACE_CODE) begin
					// saturates at zero
					if (exp_cursor != '0)
						exp_cursor = exp_cursor - 7'd1;
				end else begin
					if (!queue_cmd(SEL_DATA, r.char_code))
						ok = 1'b0;
					else
						exp_cursor = exp_cursor + 7'd1;
				end
			end
			// earlier pushes and a cleared flag stay in effect on a full queue
			if (!ok) begin
				o.status = STATUS_FULL;
			end else if (exp_cursor[3:0] == 4'd0) begin
				row_addr_due = 1'b1;
				o.status = STATUS_ROW;
			end
		end
		return o;
	endfunction

	// idle cycles before the next transaction, with stretches of none
	function automatic int draw_wait(inout bit burst);
		if ($urandom_range(0, 63) == 0)
			burst = !burst;
		if (burst || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic add_request(input logic kind, input logic [7:0] code, input bit hold);
		stim_t s;
		s.hold_for_drain = hold;
		s.item.req_type = kind;
		s.item.char_code = code;
		char_requests.push_back(s);
		total_items++;
	endtask

	// ------------------------------------------------------------------
	// driver: presents queued requests, predicts each accepted one
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			req_gap_left = 0;
		end else begin
			if (req_valid && req_ready) begin
				predicted = display_step(req);
				pending_results.push_back(predicted);
				accepted_count++;
			end
			// a new request may go out once the current one is taken
			if (!req_valid || req_ready) begin
				if (req_gap_left > 0) begin
					req_gap_left--;
					req_valid <= 1'b0;
				end else if (char_requests.size() > 0 &&
						!(char_requests[0].hold_for_drain && pending_results.size() != 0)) begin
					next_stim = char_requests.pop_front();
					req <= next_stim.item;
					req_valid <= 1'b1;
					req_gap_left = draw_wait(req_burst);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: random back-pressure, in-order comparison of each result
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result: status %0d valid %0d rs %0d byte %02h",
							rsp.status, rsp.bus_valid, rsp.bus_reg_select, rsp.bus_byte);
				end else begin
					predicted = pending_results.pop_front();
					if (rsp.status !== predicted.status || rsp.bus_valid !== predicted.bus_valid ||
							rsp.bus_reg_select !== predicted.bus_reg_select ||
							rsp.bus_byte !== predicted.bus_byte) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("mismatch: expected status %0d valid %0d rs %0d byte %02h, %s",
								predicted.status, predicted.bus_valid,
								predicted.bus_reg_select, predicted.bus_byte,
								$sformatf("got status %0d valid %0d rs %0d byte %02h",
								rsp.status, rsp.bus_valid, rsp.bus_reg_select, rsp.bus_byte));
					end
				end
				rsp_stall_left = draw_wait(rsp_burst);
			end
			if (rsp_stall_left > 0) begin
				rsp_stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lcd_text_cursor_command_queue_unit regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int         n;
		int         phase_len;
		int         tick_pct;
		int         phase_idx;
		int         pick;
		logic       kind;
		logic [7:0] code;

		exp_cursor = '0;
		row_addr_due = 1'b0;
		ring_head = 0;
		ring_tail = 0;
		foreach (ring_cmds[i])
			ring_cmds[i] = '0;
		total_items = 0;
		accepted_count = 0;
		mismatch_count = 0;
		cycle_count = 0;
		req_burst = 1'b0;
		rsp_burst = 1'b0;

		// backspace at column zero stays put and still flags a row start
		add_request(REQ_WRITE, BACKSPACE_CODE, 1'b0);
		add_request(REQ_WRITE, 8'h41, 1'b0);
		add_request(REQ_WRITE, 8'hFF, 1'b0);
		add_request(REQ_WRITE, 8'h00, 1'b0);
		// drain all four commands, then tick an empty queue
		repeat (4)
			add_request(REQ_TICK, 8'h00, 1'b0);
		add_request(REQ_TICK, 8'hFF, 1'b0);
		// newlines down to the cell past the last row
		repeat (4)
			add_request(REQ_WRITE, NEWLINE_CODE, 1'b0);
		// wrapped row address, clear, then data
		add_request(REQ_WRITE, 8'h5A, 1'b0);
		// fill the ring until a write is refused
		repeat (10)
			add_request(REQ_WRITE, 8'h61, 1'b0);
		add_request(REQ_WRITE, 8'h7E, 1'b0);

		// random phases with varied write/tick mix
		n = 0;
		phase_idx = 0;
		while (n < RANDOM_ITEMS) begin
			phase_len = $urandom_range(40, 120);
			case ($urandom_range(0, 4))
				0: tick_pct = 10;
				1: tick_pct = 30;
				2: tick_pct = 50;
				3: tick_pct = 70;
				default: tick_pct = 90;
			endcase
			for (int i = 0; i < phase_len && n < RANDOM_ITEMS; i++) begin
				kind = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_WRITE;
				pick = $urandom_range(0, 19);
				if (pick < 4)
					code = NEWLINE_CODE;
				else if (pick < 6)
					code = BACKSPACE_CODE;
				else
					code = 8'($urandom_range(0, 255));
				// every third phase waits for all results before it starts
				add_request(kind, code, (i == 0) && (phase_idx % 3 == 0));
				n++;
			end
			phase_idx++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_count != total_items || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("lcd_text_cursor_command_queue_unit regression: pass");
		end else begin
			$display("lcd_text_cursor_command_queue_unit regression: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/lcdq_pkg.sv
rtl/lcdq_ctrl.sv
rtl/lcdq_store.sv
rtl/lcd_text_cursor_command_queue_unit.sv
tb/testbench.sv
